FILE: sv/brbq_pkg.sv
// ----------------------------------------------------------------------------
// brbq_pkg
// Shared types and codes for the circular byte queue: request and response
// payloads, operation and status codes, and the update bundle that passes
// from the operation logic to the top level.
// ----------------------------------------------------------------------------
package brbq_pkg;

  // Field widths
  localparam int IDX_W  = 8;   // read/write index
  localparam int LEN_W  = 9;   // buffer length, counts
  localparam int BYTE_W = 8;

  // Default store depth and length bounds
  localparam int DEPTH_DEFAULT = 256;
  localparam int BUF_LEN_MAX   = 256;
  localparam logic [LEN_W-1:0] BUF_LEN_MIN = 9'd2;

  // Operation codes
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_ADV_RD = 2'd2;
  localparam logic [1:0] REQ_ADV_WR = 2'd3;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NO_ROOM = 2'd1;
  localparam logic [1:0] STS_EMPTY   = 2'd2;
  localparam logic [1:0] STS_CLAMPED = 2'd3;

  // Request transaction payload
  typedef struct packed {
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  count;
    logic              first_of_burst;
  } req_t;

  // Response transaction payload
  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] pop_data;
    logic [IDX_W-1:0]  data_length;
    logic [IDX_W-1:0]  contiguous_length;
    logic              is_empty;
  } rsp_t;

  // Result of one operation: next state, store access, response fields
  typedef struct packed {
    logic [IDX_W-1:0] wr_idx_next;
    logic [IDX_W-1:0] rd_idx_next;
    logic             rejected_next;
    logic             mem_we;
    logic             mem_re;
    logic [1:0]       status;
    logic [IDX_W-1:0] data_length;
    logic [IDX_W-1:0] contiguous_length;
    logic             is_empty;
  } upd_t;

endpackage

FILE: sv/byte_ring_buffer_queue_core.sv
// Response: registered in the cycle after its request is accepted; a
//   successful pop shows it after ST_READ, the store's registered read.
// Throughput: 1 request per cycle unless the response side stalls, except
//   a successful pop, which stalls requests while the byte store read completes.
// Reset: indices, burst flag and response valid clear; buffer length goes to
//   min(256, DEPTH). The byte store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// byte_ring_buffer_queue_core
// Circular byte queue over a RAM byte store with a configurable length in
// use. Supports push (with burst space check), pop, advance-read (clamped)
// and advance-write (refused on overflow). One slot always stays free.
// ----------------------------------------------------------------------------
module byte_ring_buffer_queue_core #(
  parameter int DEPTH = brbq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  brbq_pkg::req_t                req,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output brbq_pkg::rsp_t                rsp,
  // configuration
  input  logic                          cfg_we,
  input  logic [brbq_pkg::LEN_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [brbq_pkg::LEN_W-1:0] LenTop =
    (DEPTH < brbq_pkg::BUF_LEN_MAX) ? brbq_pkg::LEN_W'(DEPTH)
                                    : brbq_pkg::LEN_W'(brbq_pkg::BUF_LEN_MAX);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                            state;
  logic [brbq_pkg::IDX_W-1:0]      wr_idx;
  logic [brbq_pkg::IDX_W-1:0]      rd_idx;
  logic                            rejected;
  logic [brbq_pkg::LEN_W-1:0]      buf_len;
  logic [brbq_pkg::LEN_W-1:0]      buf_len_next;
  logic [brbq_pkg::BYTE_W-1:0]     mem_rdata;
  brbq_pkg::upd_t                  upd;
  logic                            req_fire;

  // Accept when idle and the response register is free or draining
  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign req_fire  = req_valid && req_ready;

  // Operation logic
  brbq_calc u_calc (
    .req      (req),
    .wr_idx   (wr_idx),
    .rd_idx   (rd_idx),
    .rejected (rejected),
    .buf_len  (buf_len),
    .upd      (upd)
  );

  // Byte store
  brbq_ram #(
    .WIDTH (brbq_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (req_fire && upd.mem_we),
    .waddr (AW'(wr_idx)),
    .wdata (req.data_byte),
    .re    (req_fire && upd.mem_re),
    .raddr (AW'(rd_idx)),
    .rdata (mem_rdata)
  );

  // Saturate the written length to the supported range
  always_comb begin
    if (cfg_wdata < brbq_pkg::BUF_LEN_MIN) begin
      buf_len_next = brbq_pkg::BUF_LEN_MIN;
    end else if (cfg_wdata > LenTop) begin
      buf_len_next = LenTop;
    end else begin
      buf_len_next = cfg_wdata;
    end
  end

  // Queue state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx   <= '0;
      rd_idx   <= '0;
      rejected <= 1'b0;
      buf_len  <= LenTop;
    end else if (cfg_we) begin
      wr_idx   <= '0;
      rd_idx   <= '0;
      rejected <= 1'b0;
      buf_len  <= buf_len_next;
    end else if (req_fire) begin
      wr_idx   <= upd.wr_idx_next;
      rd_idx   <= upd.rd_idx_next;
      rejected <= upd.rejected_next;
    end
  end

  // Sequencer and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            rsp_valid <= !upd.mem_re;
            state     <= upd.mem_re ? ST_READ : ST_IDLE;
          end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        ST_READ: begin
          rsp_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp.status            <= upd.status;
      rsp.pop_data          <= '0;
      rsp.data_length       <= upd.data_length;
      rsp.contiguous_length <= upd.contiguous_length;
      rsp.is_empty          <= upd.is_empty;
    end else if (state == ST_READ) begin
      rsp.pop_data <= mem_rdata;
    end
  end

  // Indices always stay inside the buffer length in use
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, wr_idx} < buf_len) && ({1'b0, rd_idx} < buf_len))
    else $error("queue index beyond buffer length");

  // No response is shown while the store read is still in flight
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !rsp_valid)
    else $error("response valid during store read");

  // A pop that reads the store always goes through ST_READ, then shows its response
  assert property (@(posedge clk) disable iff (rst)
    (req_fire && upd.mem_re) |=> (state == ST_READ) ##1 rsp_valid)
    else $error("pop did not complete after store read");

  // Emptiness agrees with the held length
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (rsp.data_length == '0)))
    else $error("empty flag disagrees with held length");

  // Only a successful pop returns a byte
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != brbq_pkg::STS_OK)) |-> (rsp.pop_data == '0))
    else $error("byte returned by a failed operation");

endmodule

FILE: sv/brbq_ram.sv
// ----------------------------------------------------------------------------
// brbq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = brbq_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/brbq_calc.sv
// ----------------------------------------------------------------------------
// brbq_calc
// Operation logic: from the current indices, burst flag and buffer length,
// works out the next indices, store access, status, held length, contiguous
// span and emptiness for one request.
// ----------------------------------------------------------------------------
module brbq_calc (
  input  brbq_pkg::req_t                  req,
  input  logic [brbq_pkg::IDX_W-1:0]      wr_idx,
  input  logic [brbq_pkg::IDX_W-1:0]      rd_idx,
  input  logic                            rejected,
  input  logic [brbq_pkg::LEN_W-1:0]      buf_len,
  output brbq_pkg::upd_t                  upd
);

  logic [brbq_pkg::LEN_W-1:0] held;
  logic [brbq_pkg::LEN_W-1:0] free_sp;
  logic [brbq_pkg::LEN_W-1:0] len_next;
  logic [brbq_pkg::IDX_W-1:0] base;
  logic [brbq_pkg::LEN_W-1:0] amt;
  logic [brbq_pkg::LEN_W:0]   sum;
  logic [brbq_pkg::IDX_W-1:0] wrapped;
  logic [brbq_pkg::LEN_W:0]   span_end;
  logic [brbq_pkg::LEN_W-1:0] tail;
  logic                       push_ok;
  logic                       rej_n;

  // Held length, wrap-safe for any buffer length
  always_comb begin
    if (wr_idx >= rd_idx) begin
      held = {1'b0, wr_idx} - {1'b0, rd_idx};
    end else begin
      held = {1'b0, wr_idx} + buf_len - {1'b0, rd_idx};
    end
    free_sp = buf_len - 9'd1 - held;
  end

  // Adder operands: read index for pop and advance-read, step of one for
  // push and pop
  assign base = (req.req_type inside {brbq_pkg::REQ_POP, brbq_pkg::REQ_ADV_RD})
                ? rd_idx : wr_idx;
  assign amt  = (req.req_type inside {brbq_pkg::REQ_PUSH, brbq_pkg::REQ_POP})
                ? 9'd1 : req.count;

  // Shared index adder with a single wrap correction (sum < 2 * length)
  always_comb begin
    sum = {2'b00, base} + {1'b0, amt};
    if (sum >= {1'b0, buf_len}) begin
      wrapped = brbq_pkg::IDX_W'(sum - {1'b0, buf_len});
    end else begin
      wrapped = brbq_pkg::IDX_W'(sum);
    end
  end

  // Burst check on the first byte of a push
  assign rej_n   = req.first_of_burst ? (req.count > free_sp) : rejected;
  assign push_ok = !rej_n && (free_sp != 9'd0);

  // Operation decode
  always_comb begin
    len_next          = held;
    upd.wr_idx_next   = wr_idx;
    upd.rd_idx_next   = rd_idx;
    upd.rejected_next = rejected;
    upd.mem_we        = 1'b0;
    upd.mem_re        = 1'b0;
    upd.status        = brbq_pkg::STS_OK;
    case (req.req_type)
      brbq_pkg::REQ_PUSH: begin
        upd.rejected_next = rej_n;
        if (push_ok) begin
          upd.mem_we      = 1'b1;
          upd.wr_idx_next = wrapped;
          len_next        = held + 9'd1;
        end else begin
          upd.status = brbq_pkg::STS_NO_ROOM;
        end
      end
      brbq_pkg::REQ_POP: begin
        if (held == 9'd0) begin
          upd.status = brbq_pkg::STS_EMPTY;
        end else begin
          upd.mem_re      = 1'b1;
          upd.rd_idx_next = wrapped;
          len_next        = held - 9'd1;
        end
      end
      brbq_pkg::REQ_ADV_RD: begin
        if (req.count > held) begin
          upd.rd_idx_next = wr_idx;
          upd.status      = brbq_pkg::STS_CLAMPED;
          len_next        = 9'd0;
        end else begin
          upd.rd_idx_next = wrapped;
          len_next        = held - req.count;
        end
      end
      brbq_pkg::REQ_ADV_WR: begin
        if (req.count > free_sp) begin
          upd.status = brbq_pkg::STS_NO_ROOM;
        end else begin
          upd.wr_idx_next = wrapped;
          len_next        = held + req.count;
        end
      end
      default: begin
        upd.status = brbq_pkg::STS_OK;
      end
    endcase

    // Contiguous span from the new read index up to the end of the buffer length in use
    span_end = {2'b00, upd.rd_idx_next} + {1'b0, len_next};
    tail     = buf_len - {1'b0, upd.rd_idx_next};
    if (span_end > {1'b0, buf_len}) begin
      upd.contiguous_length = brbq_pkg::IDX_W'(tail);
    end else begin
      upd.contiguous_length = brbq_pkg::IDX_W'(len_next);
    end
    upd.data_length = brbq_pkg::IDX_W'(len_next);
    upd.is_empty    = (upd.rd_idx_next == upd.wr_idx_next);
  end

endmodule

FILE: dv/tb_byte_ring_buffer_queue_core.sv
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_queue_core
// Self-checking bench for the circular byte queue. A behavioral copy of the
// queue (indices, burst flag, byte store) predicts every response transaction
// as requests are accepted; responses are checked in order, field by field.
// Directed cases cover empty/full edges, burst checks, index moves and length
// extremes, then random traffic runs under several buffer lengths with random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_queue_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_PHASE = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  brbq_pkg::req_t req_pl = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  brbq_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [brbq_pkg::LEN_W-1:0] cfg_wdata = '0;

  // Queue state as predicted from accepted requests
  logic [brbq_pkg::LEN_W-1:0] buf_len_reg;
  bit [brbq_pkg::IDX_W-1:0] wr_idx;
  bit [brbq_pkg::IDX_W-1:0] rd_idx;
  bit burst_rej;
  bit [brbq_pkg::BYTE_W-1:0] byte_mem [brbq_pkg::DEPTH_DEFAULT];
  bit mem_written [brbq_pkg::DEPTH_DEFAULT];

  brbq_pkg::rsp_t due_rsp_q [$];
  brbq_pkg::rsp_t got_rsp;
  brbq_pkg::rsp_t want_rsp;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int items_sent = 0;
  bit req_up = 1'b0;
  bit sender_gaps = 1'b1;
  int ready_hold = 0;

  byte_ring_buffer_queue_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req_pl),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL byte_ring_buffer_queue_core");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Queue behavior
  // --------------------------------------------------------------------------
  // length in use, saturated to 2 .. 256
  function automatic int eff_len();
    if (buf_len_reg < brbq_pkg::BUF_LEN_MIN) return 2;
    if (buf_len_reg > brbq_pkg::BUF_LEN_MAX) return brbq_pkg::BUF_LEN_MAX;
    return int'(buf_len_reg);
  endfunction

  function automatic int held_bytes();
    int l;
    l = eff_len();
    return (int'(wr_idx) + l - int'(rd_idx)) % l;
  endfunction

  function automatic int free_bytes();
    return eff_len() - 1 - held_bytes();
  endfunction

  // Apply one request to the queue and return the response it produces
  function automatic brbq_pkg::rsp_t fifo_apply_op(input brbq_pkg::req_t r);
    int l;
    int len;
    int room;
    int cnt;
    int contig;
    brbq_pkg::rsp_t o;
    l = eff_len();
    len = held_bytes();
    room = l - 1 - len;
    cnt = int'(r.count);
    o = '0;
    o.status = brbq_pkg::STS_OK;
    case (r.req_type)
      brbq_pkg::REQ_PUSH: begin
        if (r.first_of_burst) burst_rej = (cnt > room);
        if (burst_rej || room == 0) begin
          o.status = brbq_pkg::STS_NO_ROOM;
        end else begin
          byte_mem[wr_idx] = r.data_byte;
          mem_written[wr_idx] = 1'b1;
          wr_idx = brbq_pkg::IDX_W'((int'(wr_idx) + 1) % l);
        end
      end
      brbq_pkg::REQ_POP: begin
        if (len == 0) begin
          o.status = brbq_pkg::STS_EMPTY;
        end else begin
          o.pop_data = byte_mem[rd_idx];
          rd_idx = brbq_pkg::IDX_W'((int'(rd_idx) + 1) % l);
        end
      end
      brbq_pkg::REQ_ADV_RD: begin
        if (cnt > len) begin
          rd_idx = wr_idx;
          o.status = brbq_pkg::STS_CLAMPED;
        end else begin
          rd_idx = brbq_pkg::IDX_W'((int'(rd_idx) + cnt) % l);
        end
      end
      default: begin
        if (cnt > room) o.status = brbq_pkg::STS_NO_ROOM;
        else wr_idx = brbq_pkg::IDX_W'((int'(wr_idx) + cnt) % l);
      end
    endcase
    len = held_bytes();
    contig = (int'(rd_idx) + len > l) ? l - int'(rd_idx) : len;
    o.data_length = brbq_pkg::IDX_W'(len);
    o.contiguous_length = brbq_pkg::IDX_W'(contig);
    o.is_empty = (rd_idx == wr_idx);
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Response side: random stalls, in-order check
  // --------------------------------------------------------------------------
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  function automatic int ready_run_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, 20);
  endfunction

  // alternate ready runs and stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      rsp_ready <= ~rsp_ready;
      ready_hold <= rsp_ready ? stall_len() - 1 : ready_run_len() - 1;
    end
  end

  function automatic void note_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("ERROR: %s", what);
  endfunction

  // compare each response transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      got_rsp = rsp;
      if (due_rsp_q.size() == 0) begin
        note_mismatch($sformatf("unexpected response status=%0d len=%0d",
                                got_rsp.status, got_rsp.data_length));
      end else begin
        want_rsp = due_rsp_q.pop_front();
        if (got_rsp.status !== want_rsp.status ||
            got_rsp.pop_data !== want_rsp.pop_data ||
            got_rsp.data_length !== want_rsp.data_length ||
            got_rsp.contiguous_length !== want_rsp.contiguous_length ||
            got_rsp.is_empty !== want_rsp.is_empty) begin
          note_mismatch($sformatf({"cycle %0d: expected sts=%0d byte=%02h len=%0d ",
                                   "contig=%0d empty=%0d, got sts=%0d byte=%02h ",
                                   "len=%0d contig=%0d empty=%0d"},
                                  cycle_cnt, want_rsp.status, want_rsp.pop_data,
                                  want_rsp.data_length, want_rsp.contiguous_length,
                                  want_rsp.is_empty, got_rsp.status, got_rsp.pop_data,
                                  got_rsp.data_length, got_rsp.contiguous_length,
                                  got_rsp.is_empty));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Send one request transaction and predict its response once accepted
  task automatic send_req(input brbq_pkg::req_t item);
    int gap;
    // never pop a store byte that was never written
    if (item.req_type == brbq_pkg::REQ_POP && held_bytes() != 0 &&
        !mem_written[rd_idx]) begin
      item.req_type = brbq_pkg::REQ_ADV_RD;
      item.count = brbq_pkg::LEN_W'(1);
    end
    gap = sender_gaps ? gap_len() : 0;
    if (gap > 0) begin
      if (req_up) begin
        req_valid <= 1'b0;
        req_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    req_pl <= item;
    req_valid <= 1'b1;
    req_up = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    due_rsp_q.push_back(fifo_apply_op(item));
    items_sent++;
  endtask

  task automatic send_op(input logic [1:0] op, input logic [brbq_pkg::BYTE_W-1:0] d,
                         input logic [brbq_pkg::LEN_W-1:0] cnt, input logic first);
    brbq_pkg::req_t r;
    r.req_type = op;
    r.data_byte = d;
    r.count = cnt;
    r.first_of_burst = first;
    send_req(r);
  endtask

  // hold off requests until every response has come back
  task automatic drain_results();
    if (req_up) begin
      req_valid <= 1'b0;
      req_up = 1'b0;
    end
    while (due_rsp_q.size() != 0) @(posedge clk);
  endtask

  // register write while the queue is idle; also empties the queue
  task automatic set_buf_len(input logic [brbq_pkg::LEN_W-1:0] v);
    drain_results();
    repeat (3) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    buf_len_reg = v;
    wr_idx = '0;
    rd_idx = '0;
    burst_rej = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // pop and advance on the empty queue right after reset, push with no burst
  task automatic test_empty_queue();
    send_op(brbq_pkg::REQ_POP, 8'h00, 9'd0, 1'b0);
    send_op(brbq_pkg::REQ_ADV_RD, 8'h00, 9'd0, 1'b0);
    send_op(brbq_pkg::REQ_ADV_RD, 8'h00, 9'd1, 1'b0);
    send_op(brbq_pkg::REQ_PUSH, 8'h00, 9'd0, 1'b0);
    send_op(brbq_pkg::REQ_POP, 8'h00, 9'd0, 1'b0);
  endtask

  // burst space check, rejected bursts, zero-length burst, push when full
  task automatic test_push_bursts();
    set_buf_len(9'd4);
    send_op(brbq_pkg::REQ_PUSH, 8'hFF, 9'd2, 1'b1);
    send_op(brbq_pkg::REQ_PUSH, 8'hA5, 9'd2, 1'b0);
    send_op(brbq_pkg::REQ_PUSH, 8'h11, 9'd2, 1'b1);   // only one slot left
    send_op(brbq_pkg::REQ_PUSH, 8'h22, 9'd0, 1'b0);   // rest of rejected burst
    send_op(brbq_pkg::REQ_PUSH, 8'h5A, 9'd0, 1'b1);   // zero-length burst fills last slot
    send_op(brbq_pkg::REQ_PUSH, 8'h33, 9'd0, 1'b0);   // full
    repeat (4) send_op(brbq_pkg::REQ_POP, 8'h00, 9'd0, 1'b0);
    send_op(brbq_pkg::REQ_PUSH, 8'h44, 9'd256, 1'b1);
  endtask

  // advance-write refusal, advance-read clamp, zero advance, wrap
  task automatic test_index_moves();
    set_buf_len(9'd8);
    send_op(brbq_pkg::REQ_ADV_WR, 8'h00, 9'd8, 1'b0);
    send_op(brbq_pkg::REQ_ADV_WR, 8'h00, 9'd5, 1'b0);
    send_op(brbq_pkg::REQ_ADV_RD, 8'h00, 9'd0, 1'b0);
    send_op(brbq_pkg::REQ_ADV_RD, 8'h00, 9'd3, 1'b0);
    send_op(brbq_pkg::REQ_ADV_WR, 8'h00, 9'd5, 1'b0);
    send_op(brbq_pkg::REQ_ADV_RD, 8'h00, 9'd9, 1'b0);
    send_op(brbq_pkg::REQ_ADV_WR, 8'h00, 9'd0, 1'b0);
  endtask

  // length register out of range on both sides
  task automatic test_length_extremes();
    set_buf_len(9'h1FF);
    send_op(brbq_pkg::REQ_ADV_WR, 8'h00, 9'd255, 1'b0);
    send_op(brbq_pkg::REQ_ADV_WR, 8'h00, 9'd1, 1'b0);
    send_op(brbq_pkg::REQ_ADV_RD, 8'h00, 9'd256, 1'b0);
    set_buf_len(9'd0);
    send_op(brbq_pkg::REQ_PUSH, 8'h96, 9'd1, 1'b1);
    send_op(brbq_pkg::REQ_PUSH, 8'h69, 9'd0, 1'b0);
    send_op(brbq_pkg::REQ_POP, 8'h00, 9'd0, 1'b0);
    set_buf_len(9'd1);
    send_op(brbq_pkg::REQ_PUSH, 8'hC3, 9'd2, 1'b1);
  endtask

  // one well-formed burst with random content, sometimes overrun or cut short
  task automatic push_burst();
    int l;
    int blen;
    int extra;
    l = eff_len();
    if ($urandom_range(0, 9) == 0) blen = $urandom_range(0, 256);
    else blen = $urandom_range(0, (l < 24) ? l : 24);
    extra = ($urandom_range(0, 7) == 0) ? 1 : 0;
    if ($urandom_range(0, 7) == 0 && blen > 1) blen = blen / 2;
    send_op(brbq_pkg::REQ_PUSH, brbq_pkg::BYTE_W'($urandom),
            brbq_pkg::LEN_W'(blen), 1'b1);
    for (int i = 1; i < blen + extra; i++)
      send_op(brbq_pkg::REQ_PUSH, brbq_pkg::BYTE_W'($urandom),
              brbq_pkg::LEN_W'($urandom_range(0, 256)), 1'b0);
  endtask

  task automatic run_traffic(input int n);
    int target;
    int r;
    int k;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        push_burst();
      end else if (r < 65) begin
        k = $urandom_range(1, 10);
        repeat (k) send_op(brbq_pkg::REQ_POP, brbq_pkg::BYTE_W'($urandom),
                           brbq_pkg::LEN_W'($urandom_range(0, 256)), 1'($urandom));
      end else if (r < 75) begin
        k = ($urandom_range(0, 4) != 0) ? $urandom_range(0, held_bytes())
                                         : $urandom_range(0, 256);
        send_op(brbq_pkg::REQ_ADV_RD, brbq_pkg::BYTE_W'($urandom),
                brbq_pkg::LEN_W'(k), 1'($urandom));
      end else if (r < 85) begin
        k = ($urandom_range(0, 4) != 0) ? $urandom_range(0, free_bytes() + 1)
                                         : $urandom_range(0, 256);
        send_op(brbq_pkg::REQ_ADV_WR, brbq_pkg::BYTE_W'($urandom),
                brbq_pkg::LEN_W'(k), 1'($urandom));
      end else begin
        send_op(2'($urandom), brbq_pkg::BYTE_W'($urandom),
                brbq_pkg::LEN_W'($urandom_range(0, 256)), 1'($urandom));
      end
    end
  endtask

  // random traffic over several buffer lengths
  task automatic test_random_traffic();
    logic [brbq_pkg::LEN_W-1:0] len_set [8];
    len_set = '{9'd256, 9'd2, 9'd5, 9'd17, 9'd0, 9'h1FF, 9'd40, 9'd3};
    len_set[4] = brbq_pkg::LEN_W'($urandom_range(2, 256));
    len_set[7] = brbq_pkg::LEN_W'($urandom_range(2, 64));
    foreach (len_set[p]) begin
      set_buf_len(len_set[p]);
      sender_gaps = (p % 4 != 3);
      run_traffic(ITEMS_PER_PHASE / 2);
      // sender waits for every outstanding response mid-phase
      if (p == 2 || p == 6) drain_results();
      run_traffic(ITEMS_PER_PHASE / 2);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    buf_len_reg = brbq_pkg::LEN_W'(brbq_pkg::BUF_LEN_MAX);
    wr_idx = '0;
    rd_idx = '0;
    burst_rej = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    test_push_bursts();
    test_index_moves();
    test_length_extremes();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && due_rsp_q.size() == 0) begin
      $display("PASS byte_ring_buffer_queue_core");
    end else begin
      $display("FAIL byte_ring_buffer_queue_core");
    end
    $finish;
  end

endmodule
